/* rtl/core/vbf3d_pkg.sv */
// Shared constants, types and weight table for the 3D bilateral volume filter.
// Depends on nothing; the core, controller and datapath files import it.
package vbf3d_pkg;

  localparam int MAX_DIM          = 64;
  localparam int MAX_KERNEL       = 7;
  localparam int VOXEL_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int DIM_W       = 7;
  localparam int KERNEL_W    = 3;
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int H_MAX       = ((((MAX_KERNEL - 1) | 1)) - 1) / 2;
  localparam int NUM_H       = H_MAX + 1;
  localparam int H_W         = (H_MAX > 1) ? $clog2(NUM_H) : 1;
  localparam int OFF_W       = H_W + 2;
  localparam int NCOORD_W    = COORD_W + 3;
  localparam int D2_W        = $clog2(3 * H_MAX * H_MAX + 1) + 1;
  localparam int RANGE_LEN   = 192;
  localparam int RIDX_W      = $clog2(RANGE_LEN);
  localparam int WEIGHT_W    = WEIGHT_FRAC_BITS + 1;
  localparam int PROD_W      = 2 * WEIGHT_W;
  localparam int WV_W        = WEIGHT_W + VOXEL_BITS;
  localparam int MAX_TAPS    = (2 * H_MAX + 1) * (2 * H_MAX + 1) * (2 * H_MAX + 1);
  localparam int TOT_W       = WEIGHT_W + $clog2(MAX_TAPS + 1);
  localparam int ACC_W       = WV_W + $clog2(MAX_TAPS + 1);
  localparam int DIV_IDX_W   = $clog2(VOXEL_BITS);
  localparam logic [63:0] E1_Q30 = 64'd395007542;

  typedef enum logic [1:0] {
    REG_DIM_X  = 2'd0,
    REG_DIM_Y  = 2'd1,
    REG_DIM_Z  = 2'd2,
    REG_KERNEL = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTER_RD,
    S_CENTER_CAP,
    S_SWEEP,
    S_DRAIN,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic                    wr_en;
    logic                    load;
    logic                    center_rd;
    logic                    center_cap;
    logic                    issue;
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
    logic signed [OFF_W-1:0] oz;
    logic                    div_init;
    logic                    div_step;
    logic                    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_last;
  } dp_status_t;

  typedef logic [NUM_H-1:0][RANGE_LEN-1:0][WEIGHT_W-1:0] wt_tab_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] x;
    logic [63:0] ii;
    q    = udiv64(num, den);
    r    = num - q * den;
    term = 64'd1 << 30;
    pos  = '0;
    neg  = '0;
    if (q >= 64'd32) begin
      return '0;
    end
    for (int i = 0; i < 64 && term != 0; i++) begin
      ii = 64'(i);
      if (ii[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      term = udiv64(term * r, den * (ii + 64'd1));
    end
    x = pos - neg;
    for (int i = 0; i < 32; i++) begin
      if (64'(i) < q) begin
        x = (x * E1_Q30 + (64'd1 << 29)) >> 30;
      end
    end
    return x;
  endfunction

  function automatic wt_tab_t build_wt_tab();
    wt_tab_t     tab;
    logic [63:0] d;
    logic [63:0] v;
    for (int h = 0; h < NUM_H; h++) begin
      d = 64'((3 * h + 5) * (3 * h + 5));
      for (int m = 0; m < RANGE_LEN; m++) begin
        v = exp_neg_q30(64'(50 * m), d);
        tab[h][m] = WEIGHT_W'((v + (64'd1 << (29 - WEIGHT_FRAC_BITS)))
                              >> (30 - WEIGHT_FRAC_BITS));
      end
    end
    return tab;
  endfunction

  localparam wt_tab_t WT_TAB = build_wt_tab();

  function automatic logic [H_W-1:0] half_width(input logic [KERNEL_W-1:0] k);
    logic [KERNEL_W:0] ko;
    ko = {1'b0, k | KERNEL_W'(1)};
    if (ko > (KERNEL_W + 1)'(2 * H_MAX + 1)) begin
      ko = (KERNEL_W + 1)'(2 * H_MAX + 1);
    end
    return H_W'(ko >> 1);
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    if (r == '0) begin
      return DIM_W'(1);
    end
    if (r > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

/* rtl/core/volume_bilateral_filter_3d_core.sv */
// Top level of the 3D bilateral volume filter: configuration registers,
// controller and datapath. Depends on vbf3d_pkg, vbf3d_ctrl and vbf3d_dp.
//
//   Channel  Handshake            Payload
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in_valid/in_ready    action, coord_x, coord_y, coord_z, voxel_value
//   out      out_valid/out_ready  filtered_value
//
// A write request is written to the volume memory when it is accepted. A filter
// request reads the centre voxel, then every tap of the odd-edged window, drains
// the weight pipeline and runs the bit-per-cycle divider before out_valid. Its
// time is set by the window-tap reads from the single-port memory and the divider.
// The result waits in an output register while new requests are taken; a
// second filter result stalls the controller until that register is free.
// Reset is synchronous; the volume memory is not cleared.
module volume_bilateral_filter_3d_core import vbf3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [COORD_W-1:0]    coord_z,
  input  logic [VOXEL_BITS-1:0] voxel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VOXEL_BITS-1:0] filtered_value
);

  logic [DIM_W-1:0]    dim_x, dim_y, dim_z;
  logic [KERNEL_W-1:0] kernel_size;
  logic [H_W-1:0]      h;
  dp_cmd_t             cmd;
  dp_status_t          status;

  assign cfg_ready = 1'b1;
  assign h         = half_width(kernel_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x       <= DIM_W'(64);
      dim_y       <= DIM_W'(64);
      dim_z       <= DIM_W'(64);
      kernel_size <= KERNEL_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIM_X:  dim_x       <= cfg_data;
        REG_DIM_Y:  dim_y       <= cfg_data;
        REG_DIM_Z:  dim_z       <= cfg_data;
        REG_KERNEL: kernel_size <= cfg_data[KERNEL_W-1:0];
        default:    ;
      endcase
    end
  end

  vbf3d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .h         (h),
    .status    (status),
    .cmd       (cmd)
  );

  vbf3d_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .dim_x          (dim_x),
    .dim_y          (dim_y),
    .dim_z          (dim_z),
    .h              (h),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .voxel_value    (voxel_value),
    .filtered_value (filtered_value)
  );

endmodule

/* rtl/core/vbf3d_ram.sv */
// Generic single-port RAM with registered read data.
// Depends on nothing.
module vbf3d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/vbf3d_ctrl.sv */
// Controller state machine: sequences writes, the window sweep and the divider.
// Depends on vbf3d_pkg.
module vbf3d_ctrl import vbf3d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [H_W-1:0]   h,
  input  dp_status_t       status,
  output dp_cmd_t          cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic signed [OFF_W-1:0] ox;
  logic signed [OFF_W-1:0] oy;
  logic signed [OFF_W-1:0] oz;
  logic signed [OFF_W-1:0] hs;
  logic                    accept;
  logic                    last_tap;
  logic                    out_free;

  assign hs       = OFF_W'(signed'({1'b0, h}));
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_tap = (ox == hs) && (oy == hs) && (oz == hs);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (accept && action) state_next = S_CENTER_RD;
      S_CENTER_RD:  state_next = S_CENTER_CAP;
      S_CENTER_CAP: state_next = S_SWEEP;
      S_SWEEP:      if (last_tap) state_next = S_DRAIN;
      S_DRAIN:      if (!status.pipe_busy) state_next = S_DIV_INIT;
      S_DIV_INIT:   state_next = S_DIV;
      S_DIV:        if (status.div_last) state_next = S_DONE;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.ox         = ox;
    cmd.oy         = oy;
    cmd.oz         = oz;
    cmd.wr_en      = accept && !action;
    cmd.load       = accept && action;
    cmd.center_rd  = (state == S_CENTER_RD);
    cmd.center_cap = (state == S_CENTER_CAP);
    cmd.issue      = (state == S_SWEEP);
    cmd.div_init   = (state == S_DIV_INIT);
    cmd.div_step   = (state == S_DIV);
    cmd.out_load   = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ox        <= '0;
      oy        <= '0;
      oz        <= '0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        ox <= -hs;
        oy <= -hs;
        oz <= -hs;
      end else if (cmd.issue) begin
        if (ox != hs) begin
          ox <= ox + OFF_W'(1);
        end else begin
          ox <= -hs;
          if (oy != hs) begin
            oy <= oy + OFF_W'(1);
          end else begin
            oy <= -hs;
            oz <= oz + OFF_W'(1);
          end
        end
      end
    end
  end

endmodule

/* rtl/core/vbf3d_dp.sv */
// Datapath: volume store, neighbor address clamp, weight pipeline, accumulators
// and a restoring divider. Depends on vbf3d_pkg and vbf3d_ram.
module vbf3d_dp import vbf3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [DIM_W-1:0]      dim_x,
  input  logic [DIM_W-1:0]      dim_y,
  input  logic [DIM_W-1:0]      dim_z,
  input  logic [H_W-1:0]        h,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [COORD_W-1:0]    coord_z,
  input  logic [VOXEL_BITS-1:0] voxel_value,
  output logic [VOXEL_BITS-1:0] filtered_value
);

  logic [DIM_W-1:0]      dx, dy, dz;
  logic [COORD_W-1:0]    cx, cy, cz;
  logic [COORD_W-1:0]    nx, ny, nz;
  logic [ADDR_W-1:0]     ram_addr;
  logic [VOXEL_BITS-1:0] rdata;
  logic [VOXEL_BITS-1:0] center;

  logic                  a_vld, b_vld, c_vld, d_vld;
  logic [D2_W-1:0]       d2;
  logic [D2_W-1:0]       a_d2;
  logic [VOXEL_BITS-1:0] dv;
  logic [WEIGHT_W-1:0]   b_ws, b_wr;
  logic [VOXEL_BITS-1:0] b_v, c_v;
  logic [PROD_W-1:0]     c_p;
  logic [PROD_W-1:0]     p_round;
  logic [WEIGHT_W-1:0]   w;
  logic [WEIGHT_W-1:0]   d_w;
  logic [WV_W-1:0]       d_wv;
  logic [TOT_W-1:0]      total;
  logic [ACC_W-1:0]      acc;

  logic [ACC_W-1:0]      rem;
  logic [ACC_W-1:0]      dsr;
  logic [VOXEL_BITS-1:0] quot;
  logic [DIV_IDX_W-1:0]  div_idx;

  assign dx = eff_dim(dim_x);
  assign dy = eff_dim(dim_y);
  assign dz = eff_dim(dim_z);

  function automatic logic [COORD_W-1:0] clamp_n(input logic [COORD_W-1:0] c,
                                                 input logic signed [OFF_W-1:0] o,
                                                 input logic [DIM_W-1:0] d);
    logic signed [NCOORD_W-1:0] n;
    n = signed'(NCOORD_W'(c)) + NCOORD_W'(o);
    if (n < 0) begin
      return '0;
    end
    if (n >= signed'(NCOORD_W'(d))) begin
      return COORD_W'(d - DIM_W'(1));
    end
    return COORD_W'(n);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_c(input logic [COORD_W-1:0] c,
                                                 input logic [DIM_W-1:0] d);
    if (DIM_W'(c) >= d) begin
      return COORD_W'(d - DIM_W'(1));
    end
    return c;
  endfunction

  assign nx = clamp_n(cx, cmd.ox, dx);
  assign ny = clamp_n(cy, cmd.oy, dy);
  assign nz = clamp_n(cz, cmd.oz, dz);
  assign d2 = D2_W'(cmd.ox * cmd.ox) + D2_W'(cmd.oy * cmd.oy) + D2_W'(cmd.oz * cmd.oz);

  always_comb begin
    priority if (cmd.wr_en) begin
      ram_addr = {coord_z, coord_y, coord_x};
    end else if (cmd.center_rd) begin
      ram_addr = {cz, cy, cx};
    end else begin
      ram_addr = {nz, ny, nx};
    end
  end

  vbf3d_ram #(
    .WIDTH (VOXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .addr  (ram_addr),
    .wdata (voxel_value),
    .rdata (rdata)
  );

  assign dv      = (rdata > center) ? rdata - center : center - rdata;
  assign p_round = c_p + PROD_W'(1 << (WEIGHT_FRAC_BITS - 1));
  assign w       = WEIGHT_W'(p_round >> WEIGHT_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= clamp_c(coord_x, dx);
      cy <= clamp_c(coord_y, dy);
      cz <= clamp_c(coord_z, dz);
    end
    if (cmd.center_cap) begin
      center <= rdata;
    end
    a_d2 <= d2;
    b_ws <= WT_TAB[h][RIDX_W'(a_d2)];
    b_wr <= (dv < VOXEL_BITS'(RANGE_LEN)) ? WT_TAB[h][RIDX_W'(dv)] : '0;
    b_v  <= rdata;
    c_p  <= b_ws * b_wr;
    c_v  <= b_v;
    d_w  <= w;
    d_wv <= w * c_v;
    if (cmd.load) begin
      acc   <= '0;
      total <= '0;
    end else if (d_vld) begin
      acc   <= acc + ACC_W'(d_wv);
      total <= total + TOT_W'(d_w);
    end
    if (cmd.div_init) begin
      rem     <= acc + ACC_W'(total >> 1);
      dsr     <= ACC_W'(total) << (VOXEL_BITS - 1);
      div_idx <= DIV_IDX_W'(VOXEL_BITS - 1);
    end else if (cmd.div_step) begin
      if (rem >= dsr) begin
        rem  <= rem - dsr;
        quot <= {quot[VOXEL_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[VOXEL_BITS-2:0], 1'b0};
      end
      dsr     <= dsr >> 1;
      div_idx <= div_idx - DIV_IDX_W'(1);
    end
    if (cmd.out_load) begin
      filtered_value <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      a_vld <= cmd.issue;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
    end
  end

  assign status.pipe_busy = a_vld || b_vld || c_vld || d_vld;
  assign status.div_last  = (div_idx == '0);

endmodule
